// ===== hdl/xpd_pkg.sv =====
// Package: field element type, modular add/subtract helpers and register indexes.
`timescale 1ns / 1ps
package xpd_pkg;

    localparam int FIELD_BITS = 64;

    typedef logic [FIELD_BITS-1:0] t_fe;

    localparam logic CFG_PRIME = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;

    localparam logic [63:0] P_RESET = 64'hFFFF_FFFF_0000_0001;

    // a + b mod p, both operands below p
    function automatic t_fe f_add(input t_fe a, input t_fe b, input t_fe p);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    // a - b mod p, both operands below p
    function automatic t_fe f_sub(input t_fe a, input t_fe b, input t_fe p);
        t_fe r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = a + (p - b);
        end
        return r;
    endfunction

endpackage

// ===== hdl/xpd_modmul.sv =====
// Pipelined modular multiplier: one multiplier bit per stage, MSB first.
`timescale 1ns / 1ps
module xpd_modmul (
    input  logic         i_clk,
    input  logic         i_en,
    input  xpd_pkg::t_fe i_a,   // multiplicand, below p
    input  xpd_pkg::t_fe i_b,   // multiplier, any value
    input  xpd_pkg::t_fe i_p,
    output xpd_pkg::t_fe o_r
);
    import xpd_pkg::*;

    t_fe r_acc [FIELD_BITS];
    t_fe r_a   [FIELD_BITS];
    t_fe r_b   [FIELD_BITS];
    t_fe n_acc [FIELD_BITS];

    // stage k: acc = 2*acc (+ a when bit k from the top is set), all mod p
    always_comb begin
        t_fe v_acc;
        t_fe v_a;
        t_fe v_b;
        t_fe v_dbl;
        for (int k = 0; k < FIELD_BITS; k++) begin
            v_acc = (k == 0) ? '0 : r_acc[(k == 0) ? 0 : k-1];
            v_a   = (k == 0) ? i_a : r_a[(k == 0) ? 0 : k-1];
            v_b   = (k == 0) ? i_b : r_b[(k == 0) ? 0 : k-1];
            v_dbl = f_add(v_acc, v_acc, i_p);
            n_acc[k] = v_b[FIELD_BITS-1-k] ? f_add(v_dbl, v_a, i_p) : v_dbl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= n_acc[0];
            r_a[0]   <= i_a;
            r_b[0]   <= i_b;
            for (int k = 1; k < FIELD_BITS; k++) begin
                r_acc[k] <= n_acc[k];
                r_a[k]   <= r_a[k-1];
                r_b[k]   <= r_b[k-1];
            end
        end
    end

    assign o_r = r_acc[FIELD_BITS-1];

endmodule

// ===== hdl/xyzz_point_double_top.sv =====
// XYZZ point doubling over GF(p): reduction, four multiplier levels and glue stages.
// Built from five chained bit-per-stage multiplier levels (input reduction, then four
// product levels), joined by registered glue stages.
// Throughput: one request per cycle; the whole pipeline halts while a result waits.
// Reset (synchronous, active low) clears all valid bits; p returns to
// 0xFFFFFFFF00000001 and a to 0. No clearing pass.
`timescale 1ns / 1ps
module xyzz_point_double_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [255:0] i_s_axis_tdata,   // x_in, y_in, zz_in, zzz_in
    input  logic         i_s_axis_tuser,   // mode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [255:0] o_m_axis_tdata    // x_out, y_out, zz_out, zzz_out
);
    import xpd_pkg::*;

    localparam int W = FIELD_BITS;

    typedef struct packed {
        logic vld;
        logic mode;
        t_fe  x, y, zz, zzz, a, u, v, xsq, zz2, m0, w, s, azz, zz3;
        t_fe  m1, t, m, s2, m2, wy, zzz3, x3, d;
    } t_item;

    t_fe   r_p, r_a;
    logic  en;
    t_item in_item;
    t_item r_l0 [W];
    t_item r_l1 [W];
    t_item r_l2 [W];
    t_item r_l3 [W];
    t_item r_l4 [W];
    t_item r_g1, r_g2, r_g3, r_g4, r_g5, r_g6;
    t_item n_g1, n_g2, n_g3, n_g4, n_g5, n_g6;
    logic  r_out_vld;
    t_fe   r_x3, r_y3, r_zz3, r_zzz3;

    t_fe red_x, red_y, red_zz, red_zzz, red_a;
    t_fe mul_v, mul_xsq, mul_zz2, mul_w, mul_s, mul_azz, mul_zz3;
    t_fe mul_m2, mul_wy, mul_zzz3, mul_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= P_RESET[W-1:0];
            r_a <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRIME:   r_p <= i_cfg_data[W-1:0];
                CFG_CURVE_A: r_a <= i_cfg_data[W-1:0];
                default:     r_p <= r_p;
            endcase
        end
    end

    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_comb begin
        in_item = '0;
        in_item.vld  = i_s_axis_tvalid;
        in_item.mode = i_s_axis_tuser;
    end

    // level 0: reduce inputs mod p as 1 * value
    xpd_modmul u_red_x   (.i_clk, .i_en(en), .i_a(t_fe'(1)), .i_b(i_s_axis_tdata[W-1:0]),
                          .i_p(r_p), .o_r(red_x));
    xpd_modmul u_red_y   (.i_clk, .i_en(en), .i_a(t_fe'(1)), .i_b(i_s_axis_tdata[64+W-1:64]),
                          .i_p(r_p), .o_r(red_y));
    xpd_modmul u_red_zz  (.i_clk, .i_en(en), .i_a(t_fe'(1)), .i_b(i_s_axis_tdata[128+W-1:128]),
                          .i_p(r_p), .o_r(red_zz));
    xpd_modmul u_red_zzz (.i_clk, .i_en(en), .i_a(t_fe'(1)), .i_b(i_s_axis_tdata[192+W-1:192]),
                          .i_p(r_p), .o_r(red_zzz));
    xpd_modmul u_red_a   (.i_clk, .i_en(en), .i_a(t_fe'(1)), .i_b(r_a),
                          .i_p(r_p), .o_r(red_a));

    always_comb begin
        n_g1 = r_l0[W-1];
        n_g1.x = red_x;
        n_g1.y = red_y;
        n_g1.zz = red_zz;
        n_g1.zzz = red_zzz;
        n_g1.a = red_a;
        n_g1.u = f_add(red_y, red_y, r_p);
    end

    // level 1
    xpd_modmul u_v   (.i_clk, .i_en(en), .i_a(r_g1.u),  .i_b(r_g1.u),  .i_p(r_p), .o_r(mul_v));
    xpd_modmul u_xsq (.i_clk, .i_en(en), .i_a(r_g1.x),  .i_b(r_g1.x),  .i_p(r_p), .o_r(mul_xsq));
    xpd_modmul u_zz2 (.i_clk, .i_en(en), .i_a(r_g1.zz), .i_b(r_g1.zz), .i_p(r_p), .o_r(mul_zz2));

    always_comb begin
        n_g2 = r_l1[W-1];
        n_g2.v = mul_v;
        n_g2.xsq = mul_xsq;
        n_g2.zz2 = mul_zz2;
        n_g2.m0 = f_add(mul_xsq, mul_xsq, r_p);
    end

    // level 2
    xpd_modmul u_w   (.i_clk, .i_en(en), .i_a(r_g2.u), .i_b(r_g2.v),   .i_p(r_p), .o_r(mul_w));
    xpd_modmul u_s   (.i_clk, .i_en(en), .i_a(r_g2.x), .i_b(r_g2.v),   .i_p(r_p), .o_r(mul_s));
    xpd_modmul u_azz (.i_clk, .i_en(en), .i_a(r_g2.a), .i_b(r_g2.zz2), .i_p(r_p), .o_r(mul_azz));
    xpd_modmul u_zz3 (.i_clk, .i_en(en), .i_a(r_g2.v), .i_b(r_g2.zz),  .i_p(r_p), .o_r(mul_zz3));

    always_comb begin
        n_g3 = r_l2[W-1];
        n_g3.w = mul_w;
        n_g3.s = mul_s;
        n_g3.azz = mul_azz;
        n_g3.zz3 = mul_zz3;
        n_g3.m1 = f_add(r_l2[W-1].m0, r_l2[W-1].xsq, r_p);
        n_g3.t = r_l2[W-1].mode ? mul_azz : r_l2[W-1].a;
    end

    always_comb begin
        n_g4 = r_g3;
        n_g4.m = f_add(r_g3.m1, r_g3.t, r_p);
        n_g4.s2 = f_add(r_g3.s, r_g3.s, r_p);
    end

    // level 3
    xpd_modmul u_m2   (.i_clk, .i_en(en), .i_a(r_g4.m), .i_b(r_g4.m),   .i_p(r_p), .o_r(mul_m2));
    xpd_modmul u_wy   (.i_clk, .i_en(en), .i_a(r_g4.w), .i_b(r_g4.y),   .i_p(r_p), .o_r(mul_wy));
    xpd_modmul u_zzz3 (.i_clk, .i_en(en), .i_a(r_g4.w), .i_b(r_g4.zzz), .i_p(r_p), .o_r(mul_zzz3));

    always_comb begin
        n_g5 = r_l3[W-1];
        n_g5.m2 = mul_m2;
        n_g5.wy = mul_wy;
        n_g5.zzz3 = mul_zzz3;
        n_g5.x3 = f_sub(mul_m2, r_l3[W-1].s2, r_p);
    end

    always_comb begin
        n_g6 = r_g5;
        n_g6.d = f_sub(r_g5.s, r_g5.x3, r_p);
    end

    // level 4
    xpd_modmul u_md (.i_clk, .i_en(en), .i_a(r_g6.m), .i_b(r_g6.d), .i_p(r_p), .o_r(mul_md));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) begin
                r_l0[k].vld <= 1'b0;
                r_l1[k].vld <= 1'b0;
                r_l2[k].vld <= 1'b0;
                r_l3[k].vld <= 1'b0;
                r_l4[k].vld <= 1'b0;
            end
            r_g1.vld <= 1'b0;
            r_g2.vld <= 1'b0;
            r_g3.vld <= 1'b0;
            r_g4.vld <= 1'b0;
            r_g5.vld <= 1'b0;
            r_g6.vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_l0[0] <= in_item;
            r_l1[0] <= r_g1;
            r_l2[0] <= r_g2;
            r_l3[0] <= r_g4;
            r_l4[0] <= r_g6;
            for (int k = 1; k < W; k++) begin
                r_l0[k] <= r_l0[k-1];
                r_l1[k] <= r_l1[k-1];
                r_l2[k] <= r_l2[k-1];
                r_l3[k] <= r_l3[k-1];
                r_l4[k] <= r_l4[k-1];
            end
            r_g1 <= n_g1;
            r_g2 <= n_g2;
            r_g3 <= n_g3;
            r_g4 <= n_g4;
            r_g5 <= n_g5;
            r_g6 <= n_g6;
            r_out_vld <= r_l4[W-1].vld;
            // degenerate modulus (0 or 1) forces an all-zero result
            if (r_p < t_fe'(2)) begin
                r_x3 <= '0;
                r_y3 <= '0;
                r_zz3 <= '0;
                r_zzz3 <= '0;
            end else begin
                r_x3 <= r_l4[W-1].x3;
                r_y3 <= f_sub(mul_md, r_l4[W-1].wy, r_p);
                r_zz3 <= r_l4[W-1].mode ? r_l4[W-1].zz3 : r_l4[W-1].v;
                r_zzz3 <= r_l4[W-1].mode ? r_l4[W-1].zzz3 : r_l4[W-1].w;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata = {64'(r_zzz3), 64'(r_zz3), 64'(r_y3), 64'(r_x3)};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_p >= t_fe'(2)) |->
        (r_x3 < r_p && r_y3 < r_p && r_zz3 < r_p && r_zzz3 < r_p))
        else $error("result not reduced mod p");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_p < t_fe'(2) && $stable(r_p)) |-> (o_m_axis_tdata == '0))
        else $error("degenerate modulus gave non-zero result");

endmodule
